// ===== rtl/core/hls_to_rgb_converter_defines.svh =====
// Assertion macros for the HSL to RGB colour converter.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HLS_TO_RGB_CONVERTER_DEFINES_SVH
`define HLS_TO_RGB_CONVERTER_DEFINES_SVH

// Concurrent check sampled on the rising clock edge and switched off in reset.
`define HRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a consequent follows its antecedent in the next cycle.
`define HRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hrc_pkg.sv =====
// Types and constants for the HSL to RGB colour converter.
// Depends on nothing; used by hls_to_rgb_converter.
`timescale 1ns / 1ps

package hrc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int HUE_W     = FRAC_BITS;
    localparam int CHAN_W    = FRAC_BITS + 1;
    // Six times the hue needs three more bits than the hue itself.
    localparam int U_W       = FRAC_BITS + 3;

    localparam logic [CHAN_W-1:0] ONE  = CHAN_W'(1) << FRAC_BITS;
    localparam logic [CHAN_W-1:0] HALF = CHAN_W'(1) << (FRAC_BITS - 1);

    localparam logic [U_W:0] ONE_TURN   = (U_W + 1)'(1) << FRAC_BITS;
    localparam logic [U_W:0] TWO_TURN   = (U_W + 1)'(2) << FRAC_BITS;
    localparam logic [U_W:0] THREE_TURN = (U_W + 1)'(3) << FRAC_BITS;
    localparam logic [U_W:0] FOUR_TURN  = (U_W + 1)'(4) << FRAC_BITS;
    localparam logic [U_W:0] SIX_TURN   = (U_W + 1)'(6) << FRAC_BITS;

    // Segment of the piecewise-linear hue ramp.
    localparam logic [1:0] SEG_RISE = 2'd0;
    localparam logic [1:0] SEG_HIGH = 2'd1;
    localparam logic [1:0] SEG_FALL = 2'd2;
    localparam logic [1:0] SEG_LOW  = 2'd3;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] lightness;
        logic [CHAN_W-1:0] saturation;
    } hsl_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

endpackage

// ===== rtl/core/hls_to_rgb_converter.sv =====
// HSL to RGB colour converter, five-stage pipeline, one colour per clock.
// Throughput: one transaction every cycle; busy is always low and the receiver cannot stall.
// The stage holding the three 17 by 17 bit ramp multipliers sets the cycle time.
// Reset clears the valid bits of every stage; payload registers are not reset.
// Depends on hrc_pkg and hls_to_rgb_converter_defines.svh.
`timescale 1ns / 1ps

`include "hls_to_rgb_converter_defines.svh"

module hls_to_rgb_converter
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hrc_pkg::hsl_t hsl,
    output logic          done,
    output hrc_pkg::rgb_t rgb
);

    localparam int CW = hrc_pkg::CHAN_W;
    localparam int UW = hrc_pkg::U_W;
    localparam int FB = hrc_pkg::FRAC_BITS;

    // Channel order in the per-channel arrays: red, green, blue.
    logic [4:0] valid_reg;

    // Stage 1: clamping and hue positions.
    logic [CW-1:0] l1_reg, s1_reg;
    logic [UW-1:0] u1_reg [3];
    logic [CW-1:0] l1_next, s1_next;
    logic [UW-1:0] u1_next [3];

    // Stage 2: lightness times saturation.
    logic [CW-1:0] l2_reg, s2_reg, ls2_reg;
    logic [UW-1:0] u2_reg [3];
    logic [CW-1:0] ls2_next;

    // Stage 3: p, q, span and ramp segments.
    logic [CW-1:0] p3_reg, q3_reg, span3_reg;
    logic [1:0]    seg3_reg [3];
    logic [CW-1:0] f3_reg [3];
    logic [CW-1:0] p3_next, q3_next, span3_next;
    logic [1:0]    seg3_next [3];
    logic [CW-1:0] f3_next [3];

    // Stage 4: ramp products.
    logic [CW-1:0] p4_reg, q4_reg;
    logic [1:0]    seg4_reg [3];
    logic [CW-1:0] prod4_reg [3];
    logic [CW-1:0] prod4_next [3];

    // Stage 5: output register.
    hrc_pkg::rgb_t rgb_reg, rgb_next;

    assign busy = 1'b0;
    assign done = valid_reg[4];
    assign rgb  = rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], start & ~busy};
        end
    end

    // Stage 1.
    always_comb
    begin
        logic [UW-1:0] u;
        logic [UW:0]   sum_r, sum_b;
        l1_next = (hsl.lightness > hrc_pkg::ONE) ? hrc_pkg::ONE : hsl.lightness;
        s1_next = (hsl.saturation > hrc_pkg::ONE) ? hrc_pkg::ONE : hsl.saturation;
        u       = (UW'(hsl.hue) << 2) + (UW'(hsl.hue) << 1);
        sum_r   = {1'b0, u} + hrc_pkg::TWO_TURN;
        sum_b   = {1'b0, u} + hrc_pkg::FOUR_TURN;
        // Both offsets stay below twice the full six-turn range.
        if (sum_r >= hrc_pkg::SIX_TURN)
        begin
            sum_r = sum_r - hrc_pkg::SIX_TURN;
        end
        if (sum_b >= hrc_pkg::SIX_TURN)
        begin
            sum_b = sum_b - hrc_pkg::SIX_TURN;
        end
        u1_next[0] = sum_r[UW-1:0];
        u1_next[1] = u;
        u1_next[2] = sum_b[UW-1:0];
    end

    // Stage 2.
    always_comb
    begin
        logic [2*CW-1:0] prod;
        prod     = l1_reg * s1_reg;
        ls2_next = prod[FB +: CW];
    end

    // Stage 3. Zero saturation needs no special path: q and p both equal
    // lightness, so every channel comes out grey.
    always_comb
    begin
        logic [CW+1:0] q_wide, p_wide;
        logic [UW:0]   u_ext, fall;
        q_wide = (l2_reg < hrc_pkg::HALF)
               ? ((CW + 2)'(l2_reg) + (CW + 2)'(ls2_reg))
               : ((CW + 2)'(l2_reg) + (CW + 2)'(s2_reg) - (CW + 2)'(ls2_reg));
        p_wide = ((CW + 2)'(l2_reg) << 1) - q_wide;
        q3_next    = q_wide[CW-1:0];
        p3_next    = p_wide[CW-1:0];
        span3_next = q3_next - p3_next;
        for (int c = 0; c < 3; c++)
        begin
            u_ext = {1'b0, u2_reg[c]};
            fall  = hrc_pkg::FOUR_TURN - u_ext;
            if (u_ext < hrc_pkg::ONE_TURN)
            begin
                seg3_next[c] = hrc_pkg::SEG_RISE;
                f3_next[c]   = u_ext[CW-1:0];
            end
            else if (u_ext < hrc_pkg::THREE_TURN)
            begin
                seg3_next[c] = hrc_pkg::SEG_HIGH;
                f3_next[c]   = '0;
            end
            else if (u_ext < hrc_pkg::FOUR_TURN)
            begin
                seg3_next[c] = hrc_pkg::SEG_FALL;
                f3_next[c]   = fall[CW-1:0];
            end
            else
            begin
                seg3_next[c] = hrc_pkg::SEG_LOW;
                f3_next[c]   = '0;
            end
        end
    end

    // Stage 4.
    always_comb
    begin
        logic [2*CW-1:0] prod;
        for (int c = 0; c < 3; c++)
        begin
            prod          = span3_reg * f3_reg[c];
            prod4_next[c] = prod[FB +: CW];
        end
    end

    // Stage 5.
    always_comb
    begin
        logic [CW-1:0] chan [3];
        for (int c = 0; c < 3; c++)
        begin
            case (seg4_reg[c]) inside
                hrc_pkg::SEG_RISE, hrc_pkg::SEG_FALL: chan[c] = p4_reg + prod4_reg[c];
                hrc_pkg::SEG_HIGH:                    chan[c] = q4_reg;
                default:                              chan[c] = p4_reg;
            endcase
        end
        rgb_next.red   = chan[0];
        rgb_next.green = chan[1];
        rgb_next.blue  = chan[2];
    end

    always_ff @(posedge clk)
    begin
        l1_reg    <= l1_next;
        s1_reg    <= s1_next;
        l2_reg    <= l1_reg;
        s2_reg    <= s1_reg;
        ls2_reg   <= ls2_next;
        p3_reg    <= p3_next;
        q3_reg    <= q3_next;
        span3_reg <= span3_next;
        p4_reg    <= p3_reg;
        q4_reg    <= q3_reg;
        rgb_reg   <= rgb_next;
        for (int c = 0; c < 3; c++)
        begin
            u1_reg[c]    <= u1_next[c];
            u2_reg[c]    <= u1_reg[c];
            seg3_reg[c]  <= seg3_next[c];
            f3_reg[c]    <= f3_next[c];
            seg4_reg[c]  <= seg3_reg[c];
            prod4_reg[c] <= prod4_next[c];
        end
    end

    `HRC_ASSERT(a_latency, start |-> ##5 done, "transaction did not complete after five cycles")
    `HRC_ASSERT(a_range, done |-> (rgb.red <= hrc_pkg::ONE && rgb.green <= hrc_pkg::ONE && rgb.blue <= hrc_pkg::ONE), "channel above full intensity")
    `HRC_ASSERT(a_grey, (start && hsl.saturation == '0 && hsl.lightness <= hrc_pkg::ONE) |-> ##5 (rgb.red == $past(hsl.lightness, 5) && rgb.green == rgb.red && rgb.blue == rgb.red), "zero saturation did not give grey")
    `HRC_ASSERT_NEXT(a_idle, !start, !valid_reg[0], "pipeline entry without a transaction")

endmodule

// ===== dv/hls_to_rgb_converter_checker.sv =====
// Checker for the HSL to RGB colour converter: predicts each colour and compares.
// Watches the command and result ports beside the block; depends on hrc_pkg.
`timescale 1ns / 1ps

module hls_to_rgb_converter_checker
    import hrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  hsl_t hsl,
    input  logic done,
    input  rgb_t rgb,
    output int   mismatches,
    output int   pending
);

    rgb_t rgb_expected_q[$];
    int   fail_cnt    = 0;
    int   outstanding = 0;

    assign mismatches = fail_cnt;
    assign pending    = outstanding;

    // Piecewise-linear ramp between lo and hi at u, six times the hue position.
    function automatic logic [63:0] hue_ramp(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [63:0] u);
        logic [63:0] one;
        logic [63:0] span;
        one  = 64'(ONE);
        span = hi - lo;
        if (u < one)
            return lo + ((span * u) >> FRAC_BITS);
        else if (u < 3 * one)
            return hi;
        else if (u < 4 * one)
            return lo + ((span * (4 * one - u)) >> FRAC_BITS);
        else
            return lo;
    endfunction

    function automatic rgb_t hsl_to_rgb(input hsl_t c);
        logic [63:0] one;
        logic [63:0] l;
        logic [63:0] s;
        logic [63:0] ls;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] u;
        rgb_t        r;
        one = 64'(ONE);
        // Lightness and saturation above one are clipped to one.
        l = (64'(c.lightness) > one) ? one : 64'(c.lightness);
        s = (64'(c.saturation) > one) ? one : 64'(c.saturation);
        if (s == 0)
        begin
            r.red   = CHAN_W'(l);
            r.green = CHAN_W'(l);
            r.blue  = CHAN_W'(l);
            return r;
        end
        ls = (l * s) >> FRAC_BITS;
        q  = (l < 64'(HALF)) ? l + ls : l + s - ls;
        p  = 2 * l - q;
        u  = 6 * 64'(c.hue);
        r.red   = CHAN_W'(hue_ramp(p, q, (u + 2 * one) % (6 * one)));
        r.green = CHAN_W'(hue_ramp(p, q, u));
        r.blue  = CHAN_W'(hue_ramp(p, q, (u + 4 * one) % (6 * one)));
        return r;
    endfunction

    function automatic int channel_wrong(input string chan, input logic [CHAN_W-1:0] want,
                                         input logic [CHAN_W-1:0] got);
        if (got === want)
            return 0;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, chan, want, got);
        return 1;
    endfunction

    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (rgb_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, rgb);
                    fail_cnt = fail_cnt + 1;
                end
                else
                begin
                    want = rgb_expected_q.pop_front();
                    fail_cnt = fail_cnt + channel_wrong("red", want.red, rgb.red)
                             + channel_wrong("green", want.green, rgb.green)
                             + channel_wrong("blue", want.blue, rgb.blue);
                end
            end
            if (start && !busy)
                rgb_expected_q.push_back(hsl_to_rgb(hsl));
            outstanding <= rgb_expected_q.size();
        end
    end

endmodule

// ===== dv/tb_hls_to_rgb_converter.sv =====
// Testbench top for the HSL to RGB colour converter: drives directed and random colours.
// Depends on hrc_pkg, hls_to_rgb_converter and hls_to_rgb_converter_checker.
`timescale 1ns / 1ps

module tb_hls_to_rgb_converter;
    import hrc_pkg::*;

    localparam int RANDOM_PER_PHASE = 233;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 12;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    hsl_t hsl;
    rgb_t rgb;
    int   mismatches;
    int   pending;
    int   cycles;
    int   idle_pct[4] = '{0, 57, 0, 35};

    hls_to_rgb_converter i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .hsl   (hsl),
        .done  (done),
        .rgb   (rgb)
    );

    hls_to_rgb_converter_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hsl        (hsl),
        .done       (done),
        .rgb        (rgb),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("hls_to_rgb_converter test failed");
        $finish;
    end

    function automatic hsl_t colour_of(input int h, input int l, input int s);
        hsl_t c;
        c.hue        = HUE_W'(h);
        c.lightness  = CHAN_W'(l);
        c.saturation = CHAN_W'(s);
        return c;
    endfunction

    function automatic hsl_t random_colour();
        hsl_t c;
        int   k;
        k = $urandom_range(0, 5);
        // A quarter of the hues sit on a segment boundary, give or take one.
        if ($urandom_range(0, 3) == 0)
            c.hue = HUE_W'(((k << FRAC_BITS) / 6) + $urandom_range(0, 2) - 1);
        else
            c.hue = HUE_W'($urandom);
        case ($urandom_range(0, 9))
            0:       c.lightness = CHAN_W'($urandom);
            1:       c.lightness = CHAN_W'(HALF - 1 + $urandom_range(0, 1));
            2:       c.lightness = ONE;
            default: c.lightness = CHAN_W'($urandom_range(0, ONE));
        endcase
        case ($urandom_range(0, 9))
            0:       c.saturation = '0;
            1:       c.saturation = CHAN_W'($urandom);
            2:       c.saturation = ONE;
            default: c.saturation = CHAN_W'($urandom_range(0, ONE));
        endcase
        return c;
    endfunction

    // Holds start high with the colour until the transaction is taken.
    task automatic send_colour(input hsl_t c, input int gap_pct);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            hsl   <= random_colour();
            @(negedge clk);
        end
        start <= 1'b1;
        hsl   <= c;
        @(posedge clk iff !busy);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        hsl   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_colour(colour_of('h0000, 'h00000, 'h00000), 0);
        send_colour(colour_of('hFFFF, 'h10000, 'h10000), 0);
        send_colour(colour_of('h0000, 'h08000, 'h10000), 0);
        send_colour(colour_of('h5555, 'h08000, 'h10000), 0);
        send_colour(colour_of('hAAAA, 'h08000, 'h10000), 0);
        send_colour(colour_of('h2AAA, 'h08000, 'h10000), 0);
        send_colour(colour_of('h2AAB, 'h08000, 'h10000), 0);
        send_colour(colour_of('h8000, 'h07FFF, 'h10000), 0);
        send_colour(colour_of('h8000, 'h08000, 'h08000), 0);
        send_colour(colour_of('h1234, 'h1FFFF, 'h1FFFF), 0);
        send_colour(colour_of('hFFFF, 'h1FFFF, 'h00000), 0);
        send_colour(colour_of('h4000, 'h12345, 'h00000), 0);
        send_colour(colour_of('h9000, 'h10000, 'h10000), 0);
        send_colour(colour_of('hC000, 'h00000, 'h10000), 0);
        send_colour(colour_of('h0001, 'h04000, 'h00001), 0);
        send_colour(colour_of('hD555, 'h06000, 'h0C000), 0);
        send_colour(colour_of('h7FFF, 'h0FFFF, 'h1FFFF), 0);
        send_colour(colour_of('hE38E, 'h18000, 'h04000), 0);

        // Let the pipeline empty completely before the random part.
        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);

        foreach (idle_pct[ph])
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_colour(random_colour(), idle_pct[ph]);

        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("hls_to_rgb_converter test passed");
        else
            $display("hls_to_rgb_converter test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hrc_pkg.sv
rtl/core/hls_to_rgb_converter.sv
dv/hls_to_rgb_converter_checker.sv
dv/tb_hls_to_rgb_converter.sv
